// ===== src/akset_pkg.sv =====
// ----------------------------------------------------------------------------
// akset_pkg
// Shared types and codes for the array key set core.
// ----------------------------------------------------------------------------
package akset_pkg;

    localparam int KIND_W       = 2;
    localparam int KEY_W        = 32;
    localparam int COUNT_OUT_W  = 5;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_ADD      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CONTAINS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
    } item_t;

    typedef struct packed {
        logic                   ok;
        logic [COUNT_OUT_W-1:0] count_after;
    } result_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

endpackage

// ===== src/akset_cell.sv =====
// ----------------------------------------------------------------------------
// akset_cell
// One storage slot of the key ring: shifts toward its neighbor or loads.
// ----------------------------------------------------------------------------
module akset_cell
    import akset_pkg::*;
#(
    parameter int KEY_BITS = 32,
    parameter int IDX_W    = 4,
    parameter int INDEX    = 0
)
(
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    input  logic [IDX_W-1:0]    load_addr,
    input  logic [KEY_BITS-1:0] load_data,
    input  logic [KEY_BITS-1:0] shift_in,
    output logic [KEY_BITS-1:0] entry
);

    logic [KEY_BITS-1:0] entry_reg;
    logic [KEY_BITS-1:0] entry_next;
    logic                hit;

    assign hit = (load_addr == IDX_W'(INDEX));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load && hit)
        begin
            entry_next = load_data;
        end
        else if (ctrl.shift)
        begin
            entry_next = shift_in;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== src/array_key_set_core.sv =====
// ----------------------------------------------------------------------------
// array_key_set_core
// Fixed-capacity unordered key set: add, contains and swap-remove.
// Flow: a start transfer enters the scan state, which visits every cell, then
//   the write state; done and the result are registered out of the write state.
// Flow control: one operation at a time; busy covers scan and write, and start
//   is taken only once busy has dropped.
// Reset: rst_n clears the live count and control; cell contents stay
//   undefined until written. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module array_key_set_core
    import akset_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // The keys sit in a ring of cells. During a scan every cell passes its
    // key to its lower neighbor each cycle, so cell 0 (the head) shows the
    // slot numbered by step_reg. The scan shifts once per cell, so the ring
    // ends back home. The write state then loads at most one cell by index.

    state_t              state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]    step_reg, step_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [KEY_BITS-1:0] last_reg, last_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                done_reg, done_next;
    result_t             result_reg, result_next;

    cell_ctrl_t          cell_ctrl;
    logic [IDX_W-1:0]    load_addr;
    logic [KEY_BITS-1:0] load_data;
    logic [KEY_BITS-1:0] entry_w [CAPACITY];
    logic [KEY_BITS-1:0] head;

    logic [63:0]         key_wide;
    logic [KEY_BITS-1:0] key_in;
    logic [CNT_W-1:0]    step_ext;
    logic                step_live;
    logic                step_last;
    logic                has_room;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    // only the low KEY_BITS of the key field take part
    assign key_wide = {32'b0, item.key};
    assign key_in   = key_wide[KEY_BITS-1:0];

    assign head      = entry_w[0];
    assign step_ext  = CNT_W'(step_reg);
    assign step_live = (step_ext < count_reg);
    assign step_last = (CNT_W'(step_ext + CNT_W'(1)) == count_reg);
    assign has_room  = (count_reg < CNT_W'(CAPACITY));

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            akset_cell #(
                .KEY_BITS (KEY_BITS),
                .IDX_W    (IDX_W),
                .INDEX    (gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .load_addr (load_addr),
                .load_data (load_data),
                .shift_in  (entry_w[(gi + 1) % CAPACITY]),
                .entry     (entry_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        step_next       = step_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        cell_ctrl.shift = 1'b0;
        cell_ctrl.load  = 1'b0;
        load_addr       = slot_reg;
        load_data       = last_reg;
        count_ext       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next  = item.kind;
                    key_next   = key_in;
                    step_next  = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                cell_ctrl.shift = 1'b1;
                // keys are unique, so at most one slot matches
                if (step_live && (head == key_reg))
                begin
                    found_next = 1'b1;
                    slot_next  = step_reg;
                end
                // grab the last live entry for a swap-remove
                if (step_last)
                begin
                    last_next = head;
                end
                if (step_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    step_next = IDX_W'(step_reg + IDX_W'(1));
                end
            end

            ST_WRITE:
            begin
                result_next.ok = 1'b0;
                unique case (kind_reg)
                    KIND_ADD:
                    begin
                        if (found_reg)
                        begin
                            result_next.ok = 1'b1;
                        end
                        else if (has_room)
                        begin
                            // append at the first free slot
                            result_next.ok = 1'b1;
                            cell_ctrl.load = 1'b1;
                            load_addr      = count_reg[IDX_W-1:0];
                            load_data      = key_reg;
                            count_next     = CNT_W'(count_reg + CNT_W'(1));
                        end
                    end
                    KIND_CONTAINS:
                    begin
                        result_next.ok = found_reg;
                    end
                    KIND_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            // last entry fills the hole; harmless if same slot
                            result_next.ok = 1'b1;
                            cell_ctrl.load = 1'b1;
                            load_addr      = slot_reg;
                            load_data      = last_reg;
                            count_next     = CNT_W'(count_reg - CNT_W'(1));
                        end
                    end
                    default:
                    begin
                        result_next.ok = 1'b0;
                    end
                endcase
                count_ext               = {{COUNT_OUT_W{1'b0}}, count_next};
                result_next.count_after = count_ext[COUNT_OUT_W-1:0];
                done_next               = 1'b1;
                state_next              = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
            found_reg <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        slot_reg   <= slot_next;
        last_reg   <= last_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/akset_checker.sv =====
// ----------------------------------------------------------------------------
// akset_checker
// Port-level timing checks for the array key set core.
// ----------------------------------------------------------------------------
module akset_checker
    import akset_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // result strobe only appears once the core is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // a result always follows a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without preceding operation");

    // a start transfer makes the core busy and clears the strobe
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("start transfer not taken");

    // strobe lasts exactly one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held more than one cycle");

    // a strobed result carries known values
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(result))
        else $error("unknown result on strobe");

endmodule

bind array_key_set_core akset_checker u_akset_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for array_key_set_core. A queue of set operations
// (add, contains, remove, and the unused code) feeds a start/busy driver that
// sends in bursts with random gaps. A clocked monitor keeps its own copy of
// the key store, predicts the answer of every accepted transfer, and compares
// each done strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import akset_pkg::*;

    localparam int CAP         = 16;
    localparam int RESET_TICKS = 10;
    // slowest legal run is roughly 1750 items, each a full busy period plus the longest gap
    localparam int CYCLE_LIMIT = 600000;
    // drain time after the last prediction is matched
    localparam int DRAIN_TICKS = CAP + 12;
    localparam int RAND_ITEMS  = 1700;
    localparam int POOL_MAX    = 24;

    // the fourth opcode is not defined by the block; it must be a no-op
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------------
    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    done;
    result_t result;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    array_key_set_core #(
        .CAPACITY (CAP),
        .KEY_BITS (KEY_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // ------------------------------------------------------------------------
    // shared bench state
    // ------------------------------------------------------------------------
    item_t       op_queue[$];        // operations not yet sent
    result_t     expected_answers[$]; // predictions waiting for a done strobe
    int          error_count = 0;
    int          cycle_count = 0;
    logic        took_op     = 1'b0; // a transfer happened at the last rising edge

    // predictor's copy of the set; only slots below shadow_count are valid
    logic [KEY_W-1:0] shadow_keys[CAP];
    int               shadow_count = 0;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Applies one operation to the shadow set and returns the answer the
    // block should give for it.
    function automatic result_t apply_set_op(input item_t op);
        result_t ans;
        int      hit;
        int      i;
        hit = -1;
        for (i = 0; i < shadow_count; i++)
        begin
            if (hit < 0 && shadow_keys[i] == op.key)
                hit = i;
        end
        ans.ok = 1'b0;
        case (op.kind)
            KIND_ADD:
            begin
                if (hit >= 0)
                    ans.ok = 1'b1;
                else if (shadow_count < CAP)
                begin
                    shadow_keys[shadow_count] = op.key;
                    shadow_count++;
                    ans.ok = 1'b1;
                end
            end
            KIND_CONTAINS:
                ans.ok = (hit >= 0);
            KIND_REMOVE:
            begin
                // swap-remove: the last live entry fills the hole
                if (hit >= 0)
                begin
                    shadow_keys[hit] = shadow_keys[shadow_count - 1];
                    shadow_count--;
                    ans.ok = 1'b1;
                end
            end
            default: ;  // unused opcode changes nothing
        endcase
        ans.count_after = shadow_count[COUNT_OUT_W-1:0];
        return ans;
    endfunction

    task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
        item_t op;
        op.kind = kind;
        op.key  = key;
        op_queue.push_back(op);
    endtask

    // ------------------------------------------------------------------------
    // driver: changes inputs on the falling edge. start stays high until the
    // monitor sees the transfer, then the next op goes out or a gap begins.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !took_op)
        begin
            // still waiting for the block to take the current op
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
        end
        else if (op_queue.size() != 0)
        begin
            item  <= op_queue.pop_front();
            start <= 1'b1;
            if (burst_left > 1)
                burst_left <= burst_left - 1;
            else
            begin
                // pick the next burst; about a quarter run long with no gaps
                if ($urandom_range(0, 3) == 0)
                begin
                    burst_left <= $urandom_range(40, 150);
                    gap_left   <= 0;
                end
                else
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= $urandom_range(0, 40);
                end
            end
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: samples on the rising edge. Results are checked before the new
    // prediction is queued so an unexpected strobe is never paired with it.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch($sformatf("result with nothing pending: ok=%0b count=%0d",
                                              result.ok, result.count_after));
                else
                begin
                    result_t exp_r;
                    exp_r = expected_answers.pop_front();
                    if (result.ok !== exp_r.ok)
                        report_mismatch($sformatf("ok: got %b, want %b",
                                                  result.ok, exp_r.ok));
                    if (result.count_after !== exp_r.count_after)
                        report_mismatch($sformatf("count_after: got %0d, want %0d",
                                                  result.count_after, exp_r.count_after));
                end
            end
            if (start && !busy)
                expected_answers.push_back(apply_set_op(item));
            took_op <= start && !busy;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of test
    // ------------------------------------------------------------------------
    logic [KEY_W-1:0] key_pool[POOL_MAX];

    initial
    begin
        int pool_len;
        int phase_left;
        int add_pct;
        int roll;
        int n;
        int i;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;

        // directed: empty-set behavior, duplicates, unused opcode, misses
        queue_op(KIND_ADD,      32'h0000_0000);
        queue_op(KIND_CONTAINS, 32'h0000_0000);
        queue_op(KIND_ADD,      32'h0000_0000);   // already present
        queue_op(KIND_UNUSED,   32'h0000_0000);   // no-op
        queue_op(KIND_REMOVE,   32'h0000_0005);   // absent
        queue_op(KIND_CONTAINS, 32'hFFFF_FFFF);   // absent
        queue_op(KIND_REMOVE,   32'h0000_0000);   // drops the only entry
        // fill to capacity with patterned keys, extremes first
        queue_op(KIND_ADD, 32'hFFFF_FFFF);
        queue_op(KIND_ADD, 32'h0000_0000);
        queue_op(KIND_ADD, 32'h5555_5555);
        queue_op(KIND_ADD, 32'hAAAA_AAAA);
        for (i = 4; i < CAP; i++)
            queue_op(KIND_ADD, 32'h8000_0000 | (32'h1 << i));
        queue_op(KIND_ADD,      32'h1234_5678);   // full, absent: fails
        queue_op(KIND_ADD,      32'h5555_5555);   // full, present: ok
        queue_op(KIND_REMOVE,   32'hFFFF_FFFF);   // first slot, last entry moves in
        queue_op(KIND_CONTAINS, 32'h8000_8000);   // the moved key

        // random: phases lean toward filling or draining a small key pool so
        // full-store, hit and miss cases all come up; a few ops are noise
        n = 0;
        phase_left = 0;
        pool_len = 1;
        add_pct = 50;
        while (n < RAND_ITEMS)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(30, 120);
                pool_len   = $urandom_range(4, POOL_MAX);
                case ($urandom_range(0, 2))
                    0: add_pct = 70;
                    1: add_pct = 25;
                    default: add_pct = 45;
                endcase
                for (i = 0; i < POOL_MAX; i++)
                    key_pool[i] = $urandom;
                if ($urandom_range(0, 1) == 1)
                begin
                    key_pool[0] = '0;
                    key_pool[1] = '1;
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < 2)
                kind = KIND_UNUSED;
            else if (roll < add_pct)
                kind = KIND_ADD;
            else if (roll < add_pct + (100 - add_pct) / 3)
                kind = KIND_CONTAINS;
            else
                kind = KIND_REMOVE;
            if ($urandom_range(0, 99) < 4)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, pool_len - 1)];
            queue_op(kind, key);
            phase_left--;
            n++;
        end

        repeat (RESET_TICKS) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // everything sent and taken, then every prediction matched
        while (op_queue.size() != 0 || start || expected_answers.size() != 0)
            @(posedge clk);
        // catch any stray strobe
        repeat (DRAIN_TICKS) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
